// File: design/khh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// khh_pkg
// Shared types, constants and the base decoder for the k-mer hash histogram.
// ----------------------------------------------------------------------------
package khh_pkg;

    localparam int TABLE_AW    = 16;
    localparam int TABLE_DEPTH = 1 << TABLE_AW;
    localparam int HASH_OUT_W  = 16;
    localparam int COUNT_OUT_W = 32;
    localparam int MAX_RESULTS = 8;
    localparam int PAD_W       = 4;
    localparam int QDEPTH      = 4;
    localparam int QAW         = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int CHAR_W      = 8;

    typedef enum logic [1:0] {
        BASE_ACGT,
        BASE_GAP,
        BASE_BAD
    } t_base_kind;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_INCR,
        OP_READ
    } t_hist_op;

    typedef struct packed {
        t_base_kind kind;
        logic [1:0] code;
    } t_base;

    // One entry per input item that produces results: an optional main
    // result followed by pad_cnt all-zero padding results.
    typedef struct packed {
        logic                   has_main;
        logic [HASH_OUT_W-1:0]  hash_value;
        logic                   hash_valid;
        logic                   bad_base;
        logic [COUNT_OUT_W-1:0] bucket_count;
        logic [PAD_W-1:0]       pad_cnt;
    } t_rec;

    typedef struct packed {
        logic                valid;
        t_hist_op            op;
        logic [TABLE_AW-1:0] idx;
        t_rec                rec;
    } t_hist_req;

    function automatic t_base decode_base(input logic [CHAR_W-1:0] ch);
        t_base b;
        b.kind = BASE_ACGT;
        b.code = 2'd0;
        unique case (ch)
            8'h41, 8'h61: b.code = 2'd0;          // A a
            8'h43, 8'h63: b.code = 2'd1;          // C c
            8'h47, 8'h67: b.code = 2'd2;          // G g
            8'h54, 8'h74: b.code = 2'd3;          // T t
            8'h4E, 8'h6E, 8'h2A: b.kind = BASE_GAP; // N n *
            default: b.kind = BASE_BAD;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

// File: design/kmer_hash_histogram_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmer_hash_histogram_core
// 2-bit DNA k-mer hashing with a saturating 65536-bucket count histogram.
//
//   Channel   Dir  tdata (low bit up)              tuser                  tlast
//   s_axis    in   base_char[7:0],                 req_type               end_of_seq
//                  bucket_index[23:8]
//   m_axis    out  hash_value[15:0],               hash_valid, bad_base   last_result
//                  bucket_count[47:16]
//
// One item is taken per cycle while tready is high; it passes the table stage and
// the result queue into the output register. An item gives up to eight results,
// sent one per cycle while m_axis tready is high, so an end of sequence can hold
// the output with padding. After reset the count table is cleared one bucket per
// cycle, tready low until it is done. Later, tready drops only when the four-entry
// result queue plus the table stage is full because the output stalls or drains
// padding. Equal buckets hit in consecutive cycles are forwarded around the RAM.
// ----------------------------------------------------------------------------
module kmer_hash_histogram_core
    import khh_pkg::*;
#(
    parameter int KMER_LEN    = 8,
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [23:0] i_s_axis_tdata,   // base_char, bucket_index
    input  wire logic        i_s_axis_tuser,   // req_type
    input  wire logic        i_s_axis_tlast,
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [47:0]      o_m_axis_tdata,   // hash_value, bucket_count
    output logic [1:0]       o_m_axis_tuser,   // hash_valid, bad_base
    output logic             o_m_axis_tlast
);

    logic                   accept;
    t_hist_req              req;
    logic                   busy;
    logic                   s1_valid;
    logic                   push;
    t_rec                   rec;
    logic [QCNT_W-1:0]      q_count;
    logic [QCNT_W:0]        in_flight;
    logic [HASH_OUT_W-1:0]  hash_value;
    logic                   hash_valid;
    logic [COUNT_OUT_W-1:0] bucket_count;
    logic                   bad_base;

    assign in_flight       = {1'b0, q_count} + {{QCNT_W{1'b0}}, s1_valid};
    assign o_s_axis_tready = !busy && (in_flight < (QCNT_W + 1)'(QDEPTH));
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    khh_seq #(
        .KMER_LEN (KMER_LEN)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (accept),
        .i_req_type     (i_s_axis_tuser),
        .i_base_char    (i_s_axis_tdata[7:0]),
        .i_end_of_seq   (i_s_axis_tlast),
        .i_bucket_index (i_s_axis_tdata[23:8]),
        .o_req          (req)
    );

    khh_hist #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_hist (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req),
        .o_busy     (busy),
        .o_s1_valid (s1_valid),
        .o_push     (push),
        .o_rec      (rec)
    );

    khh_out u_out (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .i_rec          (rec),
        .o_count        (q_count),
        .o_valid        (o_m_axis_tvalid),
        .i_ready        (i_m_axis_tready),
        .o_hash_value   (hash_value),
        .o_hash_valid   (hash_valid),
        .o_bucket_count (bucket_count),
        .o_bad_base     (bad_base),
        .o_last         (o_m_axis_tlast)
    );

    assign o_m_axis_tdata = {bucket_count, hash_value};
    assign o_m_axis_tuser = {bad_base, hash_valid};

endmodule
`default_nettype wire

// File: design/khh_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// khh_ram
// Simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module khh_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 65536
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// File: design/khh_seq.sv
`default_nettype none
// ----------------------------------------------------------------------------
// khh_seq
// Sequence state: packs bases into the k-mer hash, tracks the valid run and
// the position, and turns each accepted item that gives a result into a histogram request.
// ----------------------------------------------------------------------------
module khh_seq
    import khh_pkg::*;
#(
    parameter int KMER_LEN = 8
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic                i_req_type,
    input  wire logic [CHAR_W-1:0]   i_base_char,
    input  wire logic                i_end_of_seq,
    input  wire logic [TABLE_AW-1:0] i_bucket_index,
    output t_hist_req                o_req
);

    localparam int HW    = 2 * KMER_LEN;
    localparam int RUN_W = $clog2(KMER_LEN + 1);
    localparam int POS_W = $clog2(KMER_LEN);
    localparam int PAD_ALONE = (KMER_LEN - 1 < MAX_RESULTS) ? KMER_LEN - 1 : MAX_RESULTS;
    localparam int PAD_AFTER = (KMER_LEN - 1 < MAX_RESULTS - 1) ? KMER_LEN - 1
                                                                : MAX_RESULTS - 1;

    logic [HW-1:0]    r_hash, n_hash;
    logic [RUN_W-1:0] r_run,  n_run;
    logic [POS_W-1:0] r_pos,  n_pos;

    t_base      base;
    logic       emit;
    logic       full_run;
    logic [31:0] hash_ext;
    t_hist_req  req;

    always_comb begin
        base     = decode_base(i_base_char);
        emit     = (r_pos == POS_W'(KMER_LEN - 1));
        n_pos    = emit ? r_pos : r_pos + POS_W'(1);
        if (base.kind == BASE_ACGT) begin
            n_hash = {r_hash[HW-3:0], base.code};
            n_run  = (r_run < RUN_W'(KMER_LEN)) ? r_run + RUN_W'(1) : r_run;
        end else begin
            n_hash = '0;
            n_run  = '0;
        end
        full_run = (n_run == RUN_W'(KMER_LEN));
        hash_ext = 32'(n_hash);

        req                  = '0;
        req.op               = OP_NONE;
        req.idx              = hash_ext[TABLE_AW-1:0];
        if (i_req_type) begin
            req.op           = OP_READ;
            req.idx          = i_bucket_index;
            req.rec.has_main = 1'b1;
        end else begin
            if (base.kind == BASE_BAD) begin
                req.rec.has_main = 1'b1;
                req.rec.bad_base = 1'b1;
            end else if (emit) begin
                req.rec.has_main = 1'b1;
                if (full_run) begin
                    req.op             = OP_INCR;
                    req.rec.hash_valid = 1'b1;
                    req.rec.hash_value = hash_ext[HASH_OUT_W-1:0];
                end
            end
            if (i_end_of_seq) begin
                req.rec.pad_cnt = req.rec.has_main ? PAD_W'(PAD_AFTER) : PAD_W'(PAD_ALONE);
            end
        end
        // Items that give no result never enter the pipeline.
        req.valid = i_accept && (req.rec.has_main || (req.rec.pad_cnt != '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hash <= '0;
            r_run  <= '0;
            r_pos  <= '0;
        end else if (i_accept && !i_req_type) begin
            if (i_end_of_seq) begin
                r_hash <= '0;
                r_run  <= '0;
                r_pos  <= '0;
            end else begin
                r_hash <= n_hash;
                r_run  <= n_run;
                r_pos  <= n_pos;
            end
        end
    end

    assign o_req = req;

endmodule
`default_nettype wire

// File: design/khh_hist.sv
`default_nettype none
// ----------------------------------------------------------------------------
// khh_hist
// Bucket count table: clearing pass after reset, then a read-modify-write
// pipeline with forwarding for back-to-back hits on one bucket.
// ----------------------------------------------------------------------------
module khh_hist
    import khh_pkg::*;
#(
    parameter int COUNT_WIDTH = 32
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_hist_req i_req,
    output logic           o_busy,
    output logic           o_s1_valid,
    output logic           o_push,
    output t_rec           o_rec
);

    localparam logic [COUNT_WIDTH-1:0] CountMax = '1;

    logic                   r_clearing;
    logic [TABLE_AW-1:0]    r_clr_addr;

    logic                   r_s1_valid;
    t_hist_op               r_s1_op;
    logic [TABLE_AW-1:0]    r_s1_idx;
    t_rec                   r_s1_rec;

    logic                   r_fwd_valid;
    logic [TABLE_AW-1:0]    r_fwd_addr;
    logic [COUNT_WIDTH-1:0] r_fwd_data;

    logic [COUNT_WIDTH-1:0] rd_data;
    logic [COUNT_WIDTH-1:0] cur_count;
    logic [COUNT_WIDTH-1:0] inc_count;
    logic                   s1_write;
    logic                   we;
    logic [TABLE_AW-1:0]    waddr;
    logic [COUNT_WIDTH-1:0] wdata;
    t_rec                   rec;

    khh_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (i_req.idx),
        .o_rdata (rd_data)
    );

    always_comb begin
        // The write made in the previous cycle is not yet in the read data.
        cur_count = (r_fwd_valid && (r_fwd_addr == r_s1_idx)) ? r_fwd_data : rd_data;
        inc_count = (cur_count == CountMax) ? cur_count : cur_count + COUNT_WIDTH'(1);
        s1_write  = r_s1_valid && (r_s1_op == OP_INCR);
        if (r_clearing) begin
            we    = 1'b1;
            waddr = r_clr_addr;
            wdata = '0;
        end else begin
            we    = s1_write;
            waddr = r_s1_idx;
            wdata = inc_count;
        end
        rec = r_s1_rec;
        if (r_s1_op == OP_READ) begin
            rec.bucket_count = COUNT_OUT_W'(cur_count);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing  <= 1'b1;
            r_clr_addr  <= '0;
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + TABLE_AW'(1);
                if (r_clr_addr == '1) begin
                    r_clearing <= 1'b0;
                end
            end
            r_s1_valid  <= i_req.valid;
            r_fwd_valid <= s1_write;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_op    <= i_req.op;
        r_s1_idx   <= i_req.idx;
        r_s1_rec   <= i_req.rec;
        r_fwd_addr <= r_s1_idx;
        r_fwd_data <= inc_count;
    end

    assign o_busy     = r_clearing;
    assign o_s1_valid = r_s1_valid;
    assign o_push     = r_s1_valid;
    assign o_rec      = rec;

endmodule
`default_nettype wire

// File: design/khh_out.sv
`default_nettype none
// ----------------------------------------------------------------------------
// khh_out
// Record queue and output register; expands each record into its main
// result, if any, and its padding results, one per cycle while the output is ready.
// ----------------------------------------------------------------------------
module khh_out
    import khh_pkg::*;
(
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire t_rec                   i_rec,
    output logic [QCNT_W-1:0]           o_count,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output logic [HASH_OUT_W-1:0]       o_hash_value,
    output logic                        o_hash_valid,
    output logic [COUNT_OUT_W-1:0]      o_bucket_count,
    output logic                        o_bad_base,
    output logic                        o_last
);

    t_rec              r_q [QDEPTH];
    logic [QAW-1:0]    r_wp;
    logic [QAW-1:0]    r_rp;
    logic [QCNT_W-1:0] r_cnt;

    logic              r_o_valid;
    t_rec              r_o_rec;
    logic              r_o_main;
    logic [PAD_W-1:0]  r_o_pad;

    logic taken;
    logic cur_last;
    logic done;
    logic load;

    always_comb begin
        taken    = r_o_valid && i_ready;
        cur_last = r_o_main ? (r_o_pad == '0) : (r_o_pad == PAD_W'(1));
        done     = taken && cur_last;
        load     = (!r_o_valid || done) && (r_cnt != '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp      <= '0;
            r_rp      <= '0;
            r_cnt     <= '0;
            r_o_valid <= 1'b0;
            r_o_main  <= 1'b0;
            r_o_pad   <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + QAW'(1);
            end
            if (load) begin
                r_rp <= r_rp + QAW'(1);
            end
            r_cnt <= r_cnt + QCNT_W'(i_push) - QCNT_W'(load);

            if (load) begin
                r_o_valid <= 1'b1;
                r_o_main  <= r_q[r_rp].has_main;
                r_o_pad   <= r_q[r_rp].pad_cnt;
            end else if (done) begin
                r_o_valid <= 1'b0;
            end else if (taken) begin
                if (r_o_main) begin
                    r_o_main <= 1'b0;
                end else begin
                    r_o_pad <= r_o_pad - PAD_W'(1);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wp] <= i_rec;
        end
        if (load) begin
            r_o_rec <= r_q[r_rp];
        end
    end

    assign o_count        = r_cnt;
    assign o_valid        = r_o_valid;
    assign o_hash_value   = r_o_main ? r_o_rec.hash_value : '0;
    assign o_hash_valid   = r_o_main && r_o_rec.hash_valid;
    assign o_bucket_count = r_o_main ? r_o_rec.bucket_count : '0;
    assign o_bad_base     = r_o_main && r_o_rec.bad_base;
    assign o_last         = cur_last;

endmodule
`default_nettype wire
